>>> src/assert_macros.svh
// Assertion macros used by the checker module of the gate controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define TLG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TLG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/tlg_pkg.sv
// Types and constants shared by the two-leaf gate controller modules.
`default_nettype none

package tlg_pkg;

  // Gate operating modes, coded as shown on gate_mode
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_OPENING = 3'd1,
    MODE_HOLDING = 3'd2,
    MODE_CLOSING = 3'd3,
    MODE_ALARM   = 3'd4
  } tlg_mode_t;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOTION_TIMEOUT = 2'd0,
    CFG_HOLD_TICKS     = 2'd1,
    CFG_STAGGER_TICKS  = 2'd2
  } tlg_cfg_idx_t;

  localparam int unsigned CfgW = 8;
  localparam int unsigned CntW = 8;

  // Register reset values
  localparam logic [CfgW-1:0] MotionTimeoutRst = 8'd78;
  localparam logic [CfgW-1:0] HoldTicksRst     = 8'd39;
  localparam logic [CfgW-1:0] StaggerTicksRst  = 8'd8;

  // Motor drive bit positions
  localparam int unsigned DrvAOpen  = 0;
  localparam int unsigned DrvBOpen  = 1;
  localparam int unsigned DrvAClose = 2;
  localparam int unsigned DrvBClose = 3;

  typedef struct packed {
    logic [CfgW-1:0] motion_timeout;
    logic [CfgW-1:0] hold_ticks;
    logic [CfgW-1:0] stagger_ticks;
  } tlg_cfg_t;

  // Input word: one sample of the gate's sensors
  typedef struct packed {
    logic tick;
    logic remote_request;
    logic leaf_a_opened;
    logic leaf_b_opened;
    logic leaf_a_closed;
    logic leaf_b_closed;
    logic obstacle;
  } tlg_in_t;

  // Result word: drives and mode after the sample
  typedef struct packed {
    logic       drive_a_open;
    logic       drive_b_open;
    logic       drive_a_close;
    logic       drive_b_close;
    logic       alarm_on;
    logic [2:0] gate_mode;
  } tlg_out_t;

endpackage

`default_nettype wire

>>> src/two_leaf_gate_controller.sv
// Top level of the two-leaf swing gate controller.
// Each input word is one sensor sample (tick, remote request, four active-low
// leaf limits, obstacle); each accepted word yields exactly one result word
// with the four motor drives, the alarm flag and the gate mode after that
// sample. A word is taken every clock while the result side keeps up, and its
// result appears on the output register in the cycle after acceptance.
// Configuration registers (index 0 motion timeout, 1 hold ticks, 2 stagger
// ticks) are written through cfg_we/cfg_idx/cfg_wdata; the user must write
// them only while the gate is idle, which the block itself leaves unenforced.
`default_nettype none

module two_leaf_gate_controller
  import tlg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_idx,
  input  wire logic [CfgW-1:0]    cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tlg_in_t            in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tlg_out_t                out_data
);

  tlg_cfg_t cfg;
  tlg_out_t res_nxt;
  logic     free;
  logic     step;

  // Accept a word whenever the result register can take its result
  assign in_stall = !free;
  assign step     = in_valid && free;

  tlg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  tlg_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .step   (step),
    .in_word(in_data),
    .res_nxt(res_nxt)
  );

  tlg_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step),
    .res_nxt  (res_nxt),
    .free     (free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> src/tlg_cfg_regs.sv
// Configuration registers of the gate controller.
`default_nettype none

module tlg_cfg_regs
  import tlg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_idx,
  input  wire logic [CfgW-1:0]      cfg_wdata,
  output tlg_cfg_t                  cfg
);

  tlg_cfg_t cfg_r;

  // Plain write port, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_timeout <= MotionTimeoutRst;
      cfg_r.hold_ticks     <= HoldTicksRst;
      cfg_r.stagger_ticks  <= StaggerTicksRst;
    end else if (cfg_we) begin
      case (tlg_cfg_idx_t'(cfg_idx))
        CFG_MOTION_TIMEOUT: cfg_r.motion_timeout <= cfg_wdata;
        CFG_HOLD_TICKS:     cfg_r.hold_ticks     <= cfg_wdata;
        CFG_STAGGER_TICKS:  cfg_r.stagger_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> src/tlg_fsm.sv
// Gate state machine: mode, tick counter, stagger flag and motor drives.
`default_nettype none

module tlg_fsm
  import tlg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tlg_cfg_t cfg,
  input  wire logic     step,      // a sample word is taken this cycle
  input  wire tlg_in_t  in_word,
  output tlg_out_t      res_nxt    // result of this sample
);

  tlg_mode_t       mode_r, mode_nxt;
  logic [CntW-1:0] elapsed_r, elapsed_nxt, el_t;
  logic [3:0]      drv_r, drv_nxt;
  logic            sd_r, sd_nxt;

  logic a_open_hit, b_open_hit, a_close_hit, b_close_hit;

  assign a_open_hit  = ~in_word.leaf_a_opened;
  assign b_open_hit  = ~in_word.leaf_b_opened;
  assign a_close_hit = ~in_word.leaf_a_closed;
  assign b_close_hit = ~in_word.leaf_b_closed;

  // Saturating tick count, bumped before the mode logic looks at it
  assign el_t = (in_word.tick && (elapsed_r != '1)) ? elapsed_r + CntW'(1) : elapsed_r;

  // Next state
  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = el_t;
    drv_nxt     = drv_r;
    sd_nxt      = sd_r;
    case (mode_r)
      MODE_IDLE: begin
        if (in_word.remote_request) begin
          mode_nxt    = MODE_OPENING;
          elapsed_nxt = '0;
          drv_nxt     = 4'b0001 << DrvAOpen;
          sd_nxt      = 1'b0;
        end
      end
      MODE_OPENING: begin
        if (!sd_r && (el_t >= cfg.stagger_ticks)) begin
          sd_nxt            = 1'b1;
          drv_nxt[DrvBOpen] = 1'b1;
        end
        if (sd_nxt) begin
          if (a_open_hit) drv_nxt[DrvAOpen] = 1'b0;
          if (b_open_hit) drv_nxt[DrvBOpen] = 1'b0;
          if (el_t > cfg.motion_timeout) begin
            mode_nxt = MODE_ALARM;
            drv_nxt  = '0;
          end else if (a_open_hit && b_open_hit) begin
            mode_nxt    = MODE_HOLDING;
            elapsed_nxt = '0;
          end
        end
      end
      MODE_HOLDING: begin
        if (el_t >= cfg.hold_ticks) begin
          mode_nxt    = MODE_CLOSING;
          elapsed_nxt = '0;
          drv_nxt     = 4'b0001 << DrvBClose;
          sd_nxt      = 1'b0;
        end
      end
      MODE_CLOSING: begin
        if (!sd_r && (el_t >= cfg.stagger_ticks)) begin
          sd_nxt             = 1'b1;
          drv_nxt[DrvAClose] = 1'b1;
        end
        if (sd_nxt) begin
          if (in_word.obstacle) begin
            // reopen from the start
            mode_nxt    = MODE_OPENING;
            elapsed_nxt = '0;
            drv_nxt     = 4'b0001 << DrvAOpen;
            sd_nxt      = 1'b0;
          end else begin
            if (a_close_hit) drv_nxt[DrvAClose] = 1'b0;
            if (b_close_hit) drv_nxt[DrvBClose] = 1'b0;
            if (el_t > cfg.motion_timeout) begin
              mode_nxt = MODE_ALARM;
              drv_nxt  = '0;
            end else if (a_close_hit && b_close_hit) begin
              mode_nxt = MODE_IDLE;
            end
          end
        end
      end
      default: begin
        // alarm latches, motors off
        mode_nxt = MODE_ALARM;
        drv_nxt  = '0;
      end
    endcase
  end

  // State registers, updated once per sample word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      elapsed_r <= '0;
      drv_r     <= '0;
      sd_r      <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      drv_r     <= drv_nxt;
      sd_r      <= sd_nxt;
    end
  end

  // Result word
  always_comb begin
    res_nxt.drive_a_open  = drv_nxt[DrvAOpen];
    res_nxt.drive_b_open  = drv_nxt[DrvBOpen];
    res_nxt.drive_a_close = drv_nxt[DrvAClose];
    res_nxt.drive_b_close = drv_nxt[DrvBClose];
    res_nxt.alarm_on      = (mode_nxt == MODE_ALARM);
    res_nxt.gate_mode     = mode_nxt;
  end

endmodule

`default_nettype wire

>>> src/tlg_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
`default_nettype none

module tlg_out_reg
  import tlg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,       // new result word this cycle
  input  wire tlg_out_t res_nxt,
  output logic          free,       // register empty or being drained
  output logic          out_valid,
  input  wire logic     out_stall,
  output tlg_out_t      out_data
);

  logic     valid_r;
  tlg_out_t data_r;

  assign free = !valid_r || !out_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  // Payload, held while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> src/tlg_checker.sv
// Port-level checker for the gate controller, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module tlg_checker
  import tlg_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire tlg_out_t out_data
);

  // Result word held while the consumer stalls
  `TLG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result word changed")

  // Input only stalls behind a waiting result
  `TLG_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with result register free")

  // Alarm flag and mode agree, and alarm means all motors off
  `TLG_ASSERT(a_alarm_flag, out_valid |-> (out_data.alarm_on == (out_data.gate_mode == MODE_ALARM)), "alarm flag and mode disagree")
  `TLG_ASSERT(a_alarm_quiet, out_valid && out_data.alarm_on |-> !out_data.drive_a_open && !out_data.drive_b_open && !out_data.drive_a_close && !out_data.drive_b_close, "motor driven in alarm")

  // Alarm latches: every later result is an alarm until reset
  `TLG_ASSERT(a_alarm_latch, out_valid && !out_stall && out_data.alarm_on |=> !out_valid || out_data.alarm_on, "alarm released without reset")

endmodule

bind two_leaf_gate_controller tlg_checker u_tlg_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

>>> tb/tb_two_leaf_gate_controller.sv
// Self-checking testbench for the two-leaf swing gate controller.
module tb_two_leaf_gate_controller;
  import tlg_pkg::*;

  // How the generator holds back ticks so that a phase cannot reach the alarm
  typedef enum int {
    GUARD_NONE,
    GUARD_MOTION,
    GUARD_OPENING
  } tick_guard_e;

  typedef struct {
    logic [CfgW-1:0] timeout;
    logic [CfgW-1:0] hold;
    logic [CfgW-1:0] stagger;
    int              words;
    int              tick_pct;
    int              move_pct;
    tick_guard_e     guard;
  } gate_phase_t;

  typedef struct {
    tlg_in_t  word;
    bit       known;
    tlg_out_t res;
  } script_row_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  tlg_cfg_idx_t    cfg_idx   = CFG_MOTION_TIMEOUT;
  logic [CfgW-1:0] cfg_wdata = '0;
  logic            in_valid  = 1'b0;
  tlg_in_t         in_data   = '0;
  logic            in_stall;
  logic            out_valid;
  logic            out_stall = 1'b0;
  tlg_out_t        out_data;

  two_leaf_gate_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predicted gate state and timing registers
  tlg_mode_t       gmode         = MODE_IDLE;
  logic [CntW-1:0] elapsed_ticks = '0;
  logic [3:0]      drives        = '0;
  bit              stagger_met   = 1'b0;
  logic [CfgW-1:0] timeout_ticks = MotionTimeoutRst;
  logic [CfgW-1:0] hold_time     = HoldTicksRst;
  logic [CfgW-1:0] stagger_time  = StaggerTicksRst;

  // Leaf positions seen by the sensor generator
  bit a_wide = 1'b0, b_wide = 1'b0, a_shut = 1'b1, b_shut = 1'b1;

  tlg_out_t outputs_due [$];
  int       mismatches = 0;
  int       burst_left = 0;
  int       stall_style = 0, stall_left = 0;

  function automatic tlg_out_t mk_res(logic [3:0] drv, tlg_mode_t m);
    tlg_out_t r;
    r.drive_a_open  = drv[DrvAOpen];
    r.drive_b_open  = drv[DrvBOpen];
    r.drive_a_close = drv[DrvAClose];
    r.drive_b_close = drv[DrvBClose];
    r.alarm_on      = (m == MODE_ALARM);
    r.gate_mode     = m;
    return r;
  endfunction

  function automatic void start_motion(tlg_mode_t m, int drv_bit);
    gmode          = m;
    elapsed_ticks  = '0;
    drives         = '0;
    drives[drv_bit] = 1'b1;
    stagger_met    = 1'b0;
  endfunction

  // Next gate state for one sensor word; returns the outputs it should show
  function automatic tlg_out_t advance_gate(tlg_in_t w);
    bit a_op, b_op, a_cl, b_cl;
    a_op = !w.leaf_a_opened;
    b_op = !w.leaf_b_opened;
    a_cl = !w.leaf_a_closed;
    b_cl = !w.leaf_b_closed;
    if (w.tick && elapsed_ticks != '1) elapsed_ticks = elapsed_ticks + 1'b1;
    case (gmode)
      MODE_IDLE: begin
        if (w.remote_request) start_motion(MODE_OPENING, DrvAOpen);
      end
      MODE_OPENING: begin
        if (!stagger_met && elapsed_ticks >= stagger_time) begin
          stagger_met = 1'b1;
          drives[DrvBOpen] = 1'b1;
        end
        if (stagger_met) begin
          if (a_op) drives[DrvAOpen] = 1'b0;
          if (b_op) drives[DrvBOpen] = 1'b0;
          if (elapsed_ticks > timeout_ticks) begin
            gmode  = MODE_ALARM;
            drives = '0;
          end else if (a_op && b_op) begin
            gmode         = MODE_HOLDING;
            elapsed_ticks = '0;
          end
        end
      end
      MODE_HOLDING: begin
        if (elapsed_ticks >= hold_time) start_motion(MODE_CLOSING, DrvBClose);
      end
      MODE_CLOSING: begin
        if (!stagger_met && elapsed_ticks >= stagger_time) begin
          stagger_met = 1'b1;
          drives[DrvAClose] = 1'b1;
        end
        if (stagger_met) begin
          // obstacle beats limits and timeout: reopen from the start
          if (w.obstacle) begin
            start_motion(MODE_OPENING, DrvAOpen);
          end else begin
            if (a_cl) drives[DrvAClose] = 1'b0;
            if (b_cl) drives[DrvBClose] = 1'b0;
            if (elapsed_ticks > timeout_ticks) begin
              gmode  = MODE_ALARM;
              drives = '0;
            end else if (a_cl && b_cl) begin
              gmode = MODE_IDLE;
            end
          end
        end
      end
      default: begin
        gmode  = MODE_ALARM;
        drives = '0;
      end
    endcase
    return mk_res(drives, gmode);
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Sensor word from the leaf positions, which follow the predicted drives
  function automatic tlg_in_t next_sample(gate_phase_t ph, bit settle);
    tlg_in_t w;
    int      move_pct;
    bit      hold_tick;
    int      gbit;
    move_pct = settle ? 60 : ph.move_pct;
    if (drives[DrvAOpen]) begin
      a_shut = 1'b0;
      if (roll(move_pct)) a_wide = 1'b1;
    end
    if (drives[DrvAClose]) begin
      a_wide = 1'b0;
      if (roll(move_pct)) a_shut = 1'b1;
    end
    if (drives[DrvBOpen]) begin
      b_shut = 1'b0;
      if (roll(move_pct)) b_wide = 1'b1;
    end
    if (drives[DrvBClose]) begin
      b_wide = 1'b0;
      if (roll(move_pct)) b_shut = 1'b1;
    end
    // while winding back, a leaf stopped short by a glitch counts as at its limit
    if (settle && stagger_met) begin
      if (gmode == MODE_OPENING) begin
        if (!drives[DrvAOpen]) a_wide = 1'b1;
        if (!drives[DrvBOpen]) b_wide = 1'b1;
      end
      if (gmode == MODE_CLOSING) begin
        if (!drives[DrvAClose]) a_shut = 1'b1;
        if (!drives[DrvBClose]) b_shut = 1'b1;
      end
    end
    w.tick = roll(settle ? 100 : ph.tick_pct);
    w.remote_request = roll((gmode == MODE_IDLE) ? (settle ? 0 : 35) : 15);
    w.leaf_a_opened  = !a_wide;
    w.leaf_b_opened  = !b_wide;
    w.leaf_a_closed  = !a_shut;
    w.leaf_b_closed  = !b_shut;
    w.obstacle       = roll(settle ? 0 : ((gmode == MODE_CLOSING) ? 10 : 5));
    if (!settle) begin
      // limit switch glitches and the odd fully random word
      if (roll(4)) begin
        gbit    = $urandom_range(1, 4);
        w[gbit] = ~w[gbit];
      end
      if (roll(2)) w = tlg_in_t'($urandom);
    end
    // keep elapsed from passing the timeout where the phase must not alarm
    case (ph.guard)
      GUARD_MOTION:  hold_tick = (gmode == MODE_OPENING) || (gmode == MODE_CLOSING);
      GUARD_OPENING: hold_tick = (gmode == MODE_OPENING);
      default:       hold_tick = 1'b0;
    endcase
    if (hold_tick && elapsed_ticks >= timeout_ticks) w.tick = 1'b0;
    return w;
  endfunction

  // Offer one word in bursts with random gaps, then log what it should give
  task automatic send_word(tlg_in_t w, bit known, tlg_out_t res);
    int       gap;
    tlg_out_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predicted = advance_gate(w);
    outputs_due.push_back(known ? res : predicted);
  endtask

  // Stop sending and let every expected word come back
  task automatic quiesce();
    int waited;
    waited     = 0;
    in_valid   <= 1'b0;
    burst_left = 0;
    while (outputs_due.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (outputs_due.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, outputs_due.size());
      mismatches++;
    end
    repeat (3) @(posedge clk);
  endtask

  // Timing registers, one per cycle, with the gate idle
  task automatic load_timing(logic [CfgW-1:0] t, logic [CfgW-1:0] h, logic [CfgW-1:0] s);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MOTION_TIMEOUT;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_idx   <= CFG_HOLD_TICKS;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_idx   <= CFG_STAGGER_TICKS;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_ticks = t;
    hold_time     = h;
    stagger_time  = s;
  endtask

  task automatic flag_field(string name, logic [2:0] want, logic [2:0] got);
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    mismatches++;
  endtask

  // Result side: stall pattern and field-by-field compare
  always @(posedge clk) begin : result_check
    tlg_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outputs_due.size() == 0) begin
        $display("%0t: result word %p with nothing expected", $time, out_data);
        mismatches++;
      end else begin
        want = outputs_due.pop_front();
        if (want.drive_a_open !== out_data.drive_a_open)
          flag_field("drive_a_open", want.drive_a_open, out_data.drive_a_open);
        if (want.drive_b_open !== out_data.drive_b_open)
          flag_field("drive_b_open", want.drive_b_open, out_data.drive_b_open);
        if (want.drive_a_close !== out_data.drive_a_close)
          flag_field("drive_a_close", want.drive_a_close, out_data.drive_a_close);
        if (want.drive_b_close !== out_data.drive_b_close)
          flag_field("drive_b_close", want.drive_b_close, out_data.drive_b_close);
        if (want.alarm_on !== out_data.alarm_on)
          flag_field("alarm_on", want.alarm_on, out_data.alarm_on);
        if (want.gate_mode !== out_data.gate_mode)
          flag_field("gate_mode", want.gate_mode, out_data.gate_mode);
      end
    end
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_left  = $urandom_range(4, 50);
    end
    stall_left--;
    case (stall_style)
      1:       out_stall <= roll(35);
      2:       out_stall <= roll(80);
      default: out_stall <= 1'b0;
    endcase
  end

  script_row_t script [16];
  gate_phase_t plan [6];

  initial begin
    bit settle;
    int n;
    //            t r ao bo ac bc ob
    script = '{
      '{7'b0_0_0_0_0_0_0, 1'b1, mk_res(4'b0000, MODE_IDLE)},
      '{7'b1_0_1_1_1_1_1, 1'b1, mk_res(4'b0000, MODE_IDLE)},
      // all ones: request starts opening, tick on that word not counted
      '{7'b1_1_1_1_1_1_1, 1'b1, mk_res(4'b0001, MODE_OPENING)},
      // limits and obstacle ignored while staggering
      '{7'b1_0_0_0_1_1_1, 1'b1, mk_res(4'b0001, MODE_OPENING)},
      '{7'b1_0_1_1_0_0_0, 1'b0, '0},
      '{7'b1_0_1_1_0_0_0, 1'b0, '0},
      '{7'b1_0_1_1_0_0_0, 1'b0, '0},
      '{7'b1_0_1_1_0_0_0, 1'b0, '0},
      '{7'b1_0_1_1_0_0_0, 1'b0, '0},
      '{7'b1_0_1_1_0_0_0, 1'b1, mk_res(4'b0001, MODE_OPENING)},
      // eighth counted tick: leaf B joins, stray request ignored
      '{7'b1_1_1_1_1_1_0, 1'b1, mk_res(4'b0011, MODE_OPENING)},
      '{7'b0_0_0_1_1_1_0, 1'b1, mk_res(4'b0010, MODE_OPENING)},
      '{7'b0_1_0_1_1_1_1, 1'b1, mk_res(4'b0010, MODE_OPENING)},
      '{7'b1_0_0_0_1_1_0, 1'b1, mk_res(4'b0000, MODE_HOLDING)},
      '{7'b1_1_1_1_1_1_1, 1'b1, mk_res(4'b0000, MODE_HOLDING)},
      '{7'b0_0_0_0_0_0_1, 1'b0, '0}
    };
    // timeout, hold, stagger, words, tick %, move %, guard
    plan = '{
      '{8'd78,  8'd39,  8'd8,   200, 70, 40, GUARD_MOTION},
      '{8'd255, 8'd0,   8'd0,   250, 50, 35, GUARD_NONE},
      '{8'd255, 8'd255, 8'd255, 150, 95, 25, GUARD_NONE},
      '{8'd20,  8'd5,   8'd3,   250, 60, 20, GUARD_MOTION},
      '{8'd1,   8'd1,   8'd1,   250, 60, 40, GUARD_MOTION},
      // last phase ends in the latched alarm, raised while closing
      '{8'd0,   8'd0,   8'd0,   150, 70, 30, GUARD_OPENING}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) send_word(script[i].word, script[i].known, script[i].res);
    a_wide = 1'b1;
    b_wide = 1'b1;
    a_shut = 1'b0;
    b_shut = 1'b0;

    foreach (plan[p]) begin
      if (p > 0) begin
        quiesce();
        load_timing(plan[p].timeout, plan[p].hold, plan[p].stagger);
      end
      // past the word count, wind the gate back to idle before the next setting
      n = 0;
      settle = 1'b0;
      while (!settle || (gmode != MODE_IDLE && p < $size(plan) - 1)) begin
        send_word(next_sample(plan[p], settle), 1'b0, '0);
        n++;
        settle = (n >= plan[p].words);
        if (settle && p == $size(plan) - 1) break;
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/tlg_pkg.sv
src/tlg_cfg_regs.sv
src/tlg_fsm.sv
src/tlg_out_reg.sv
src/two_leaf_gate_controller.sv
src/tlg_checker.sv
tb/tb_two_leaf_gate_controller.sv
